FILE: hdl/ntc_pkg.sv
package ntc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned TempW   = 16;
  localparam int unsigned ResW    = 22;
  localparam int unsigned BetaW   = 16;
  localparam int unsigned NomW    = 8;
  localparam int unsigned BitsW   = 5;
  localparam int unsigned DiffW   = 31;              // full scale minus sample, up to 2^31-1
  localparam int unsigned ProdW   = ResW + DiffW;    // 53 bit product
  localparam int unsigned MantW   = 31;              // Q30 mantissa, value in [1,2)
  localparam int unsigned ExpW    = 6;
  localparam int unsigned ZeroK   = 27315;
  localparam int unsigned TempMax = 32767;

  typedef enum logic [1:0] {
    ErrNone   = 2'd0,
    ErrSample = 2'd1,
    ErrRange  = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    RegSeries  = 3'd0,
    RegNominal = 3'd1,
    RegBeta    = 3'd2,
    RegNomTemp = 3'd3,
    RegAdcBits = 3'd4
  } reg_e;

  // pre-checked verdict travelling with each item
  typedef struct packed {
    logic       early;  // result already known, bypass arithmetic
    logic       neg;    // early result is -27315 instead of +32767
    err_e       err;
  } flag_t;

endpackage

FILE: hdl/ntc_log2.sv
// pipelined log2 of a positive integer: one squaring step per stage
module ntc_log2 import ntc_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ProdW-1:0]             x_i,
  output logic [ExpW+FracBits-1:0]     log_o
);

  logic [ExpW-1:0]  exp_q  [FracBits+1];
  logic [MantW-1:0] mant_q [FracBits+1];
  logic [FracBits-1:0] frac_q [FracBits+1];

  logic [ExpW-1:0]  p_d;
  logic [MantW-1:0] m_d;

  always_comb begin
    p_d = '0;
    for (int b = 0; b < ProdW; b++) begin
      if (x_i[b]) p_d = ExpW'(b);
    end
    if (p_d > ExpW'(30)) m_d = MantW'(x_i >> (p_d - ExpW'(30)));
    else                 m_d = MantW'(x_i << (ExpW'(30) - p_d));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exp_q[0]  <= p_d;
      mant_q[0] <= m_d;
      frac_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < FracBits; s++) begin : g_sq
    logic [2*MantW-1:0] sq;
    logic [MantW+1:0]   y;
    assign sq = mant_q[s] * mant_q[s];
    assign y  = (MantW+2)'(sq >> 30);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        exp_q[s+1] <= exp_q[s];
        if (y[31]) begin
          mant_q[s+1] <= MantW'(y >> 1);
          frac_q[s+1] <= {frac_q[s][FracBits-2:0], 1'b1};
        end else begin
          mant_q[s+1] <= MantW'(y);
          frac_q[s+1] <= {frac_q[s][FracBits-2:0], 1'b0};
        end
      end
    end
  end

  assign log_o = {exp_q[FracBits], frac_q[FracBits]};

endmodule

FILE: hdl/ntc_div.sv
// pipelined restoring divider, one quotient bit per stage
module ntc_div import ntc_pkg::*; #(
  parameter int unsigned NumW = 72,
  parameter int unsigned DenW = 48,
  parameter int unsigned QW   = 16
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QW-1:0]   quo_o
);
  // quotient assumed below 2^QW; caller saturates beforehand
  logic [NumW-1:0] num_q [QW+1];
  logic [DenW-1:0] den_q [QW+1];
  logic [QW-1:0]   quo_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_st
    localparam int unsigned Sh = QW - 1 - s;
    logic [NumW+DenW:0] trial;
    logic [NumW+DenW:0] dsh;
    logic [NumW+DenW:0] cur;
    assign cur   = {{(DenW+1){1'b0}}, num_q[s]};
    assign dsh   = (NumW+DenW+1)'(den_q[s]) << Sh;
    assign trial = cur - dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1] <= den_q[s];
        if (cur >= dsh) begin
          num_q[s+1] <= NumW'(trial);
          quo_q[s+1] <= quo_q[s] | (QW'(1) << Sh);
        end else begin
          num_q[s+1] <= num_q[s];
          quo_q[s+1] <= quo_q[s];
        end
      end
    end
  end

  assign quo_o = quo_q[QW];

endmodule

FILE: hdl/ntc_adc_to_temperature.sv
// NTC thermistor to temperature, beta equation. One adc sample beat in gives one
// result beat out: temperature in 0.01 C (signed 16 bit, saturated) and an error
// code (0 ok, 1 sample zero or at or above full scale, 2 out of range). It is a
// fixed pipeline that accepts a beat every cycle while the output is not stalled;
// its depth is set by one squaring stage per log fraction bit and one stage per
// quotient bit of the final divide. The whole pipeline advances only when the
// output stage can move, so backpressure stalls everything without loss. The
// user must write registers over apb only while the pipe is empty; not enforced.
module ntc_adc_to_temperature import ntc_pkg::*; #(
  parameter int unsigned LOG_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] adc_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [15:0] temp_centi_c, [17:16] error_code
);

  localparam int unsigned F     = LOG_FRAC_BITS;
  localparam int unsigned LogW  = ExpW + F;
  localparam int unsigned DW    = LogW + 1;          // signed log difference
  localparam int unsigned LW    = DW;                // ln magnitude fits
  localparam int unsigned CkW   = 16;                // centi-kelvin of t0
  localparam int unsigned BcW   = 23;                // 100*beta
  localparam int unsigned DenW  = BcW + F + 3;       // D, signed
  localparam int unsigned NumW  = BcW + CkW + F + 1;
  localparam int unsigned QW    = 17;
  localparam int unsigned LogLat = F + 1;
  localparam int unsigned Depth  = LogLat + 5 + QW + 2;
  localparam logic [32:0] Ln2Q32 = 33'h0B17217F8;

  // ---------------- configuration
  logic [ResW-1:0]  series_q, nominal_q;
  logic [BetaW-1:0] beta_q;
  logic [NomW-1:0]  nomt_q;
  logic [BitsW-1:0] bits_q;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_q  <= ResW'(10000);
      nominal_q <= ResW'(10000);
      beta_q    <= BetaW'(3435);
      nomt_q    <= NomW'(25);
      bits_q    <= BitsW'(10);
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[4:2])
        RegSeries:  series_q  <= pwdata[ResW-1:0];
        RegNominal: nominal_q <= pwdata[ResW-1:0];
        RegBeta:    beta_q    <= pwdata[BetaW-1:0];
        RegNomTemp: nomt_q    <= pwdata[NomW-1:0];
        RegAdcBits: bits_q    <= pwdata[BitsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegSeries:  prdata = 32'(series_q);
      RegNominal: prdata = 32'(nominal_q);
      RegBeta:    prdata = 32'(beta_q);
      RegNomTemp: prdata = 32'(nomt_q);
      RegAdcBits: prdata = 32'(bits_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------- pipeline control: single enable, valid shift
  logic             en;
  logic [Depth-1:0] vld_q;
  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
  end

  // ---------------- stage 0: checks and products
  logic [31:0]      fs;
  logic [SampleW-1:0] raw;
  flag_t            flag0;
  logic [ProdW-1:0] num0, den0;
  logic [DiffW-1:0] diff;

  assign raw  = s_axis_tdata;
  assign fs   = (bits_q > BitsW'(31)) ? 32'h7fffffff : ((32'd1 << bits_q) - 32'd1);
  // full scale may reach 2^31-1 for wide resolutions
  assign diff = DiffW'(fs - 32'(raw));

  always_comb begin
    flag0 = '{early: 1'b0, neg: 1'b0, err: ErrNone};
    if (raw == '0 || 32'(raw) >= fs) flag0 = '{early: 1'b1, neg: 1'b0, err: ErrSample};
    else if (series_q == '0)        flag0 = '{early: 1'b1, neg: 1'b0, err: ErrRange};
    else if (nominal_q == '0)       flag0 = '{early: 1'b1, neg: 1'b1, err: ErrRange};
    // keep log input nonzero on early items
    num0 = flag0.early ? ProdW'(1) : ProdW'(series_q) * ProdW'(raw);
    den0 = flag0.early ? ProdW'(1) : ProdW'(nominal_q) * ProdW'(diff);
  end

  logic [LogW-1:0] lnum, lden;
  ntc_log2 #(.FracBits(F)) u_lnum (.clk_i, .en_i(en), .x_i(num0), .log_o(lnum));
  ntc_log2 #(.FracBits(F)) u_lden (.clk_i, .en_i(en), .x_i(den0), .log_o(lden));

  // side band through the log stages
  flag_t            flag_q [LogLat+4];
  logic [BcW-1:0]   bc_q   [LogLat+3];
  logic [CkW-1:0]   ck_q   [LogLat+3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      flag_q[0] <= flag0;
      bc_q[0]   <= BcW'(beta_q) * BcW'(100);
      ck_q[0]   <= CkW'(nomt_q) * CkW'(100) + CkW'(ZeroK);
      for (int k = 1; k < LogLat + 4; k++) begin
        flag_q[k] <= flag_q[k-1];
      end
      for (int k = 1; k < LogLat + 3; k++) begin
        bc_q[k]   <= bc_q[k-1];
        ck_q[k]   <= ck_q[k-1];
      end
    end
  end

  // stage a: difference and magnitude
  logic [DW-1:0] d;
  logic          dneg_q;
  logic [DW-1:0] dmag_q;
  assign d = DW'(lnum) - DW'(lden);
  always_ff @(posedge clk_i) begin
    if (en) begin
      dneg_q <= d[DW-1];
      dmag_q <= d[DW-1] ? DW'(-d) : d;
    end
  end

  // stage b: times ln2, rounded
  logic [DW+32:0] lprod;
  logic           lneg_q;
  logic [LW-1:0]  lmag_q;
  assign lprod = (DW+33)'(dmag_q) * (DW+33)'(Ln2Q32) + (DW+33)'(33'h080000000);
  always_ff @(posedge clk_i) begin
    if (en) begin
      lneg_q <= dneg_q;
      lmag_q <= LW'(lprod >> 32);
    end
  end

  // stage c: L*t0c
  logic [LW+CkW-1:0] lt_q;
  logic              ltneg_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      lt_q    <= (LW+CkW)'(lmag_q) * (LW+CkW)'(ck_q[LogLat+1]);
      ltneg_q <= lneg_q;
    end
  end

  // stage d: D and numerator
  localparam int unsigned SW = LW + CkW + 2;
  logic signed [SW-1:0] dsum;
  logic signed [SW-1:0] dsum_q;
  logic [NumW-1:0]      numer_q;
  assign dsum = $signed(SW'(bc_q[LogLat+2]) << F)
              + (ltneg_q ? -$signed(SW'(lt_q)) : $signed(SW'(lt_q)));
  always_ff @(posedge clk_i) begin
    if (en) begin
      dsum_q  <= dsum;
      numer_q <= (NumW'(bc_q[LogLat+2]) * NumW'(ck_q[LogLat+2])) << F;
    end
  end

  // stage e: range precheck and divider operands
  localparam int unsigned NdW = NumW + 1;
  logic [SW-1:0]  dpos;
  logic [NdW-1:0] nr;
  logic           dbad;
  logic           qbig;
  logic [NdW+QW:0] lim;
  assign dpos = dsum_q;
  assign dbad = dsum_q <= 0;
  assign nr   = NdW'(numer_q) + NdW'(dpos >> 1);
  // quotient > 60082 (or beyond QW bits) is out of range
  assign lim  = (NdW+QW+1)'(dpos) * (NdW+QW+1)'(32767 + ZeroK + 1);
  assign qbig = (NdW+QW+1)'(nr) >= lim;

  flag_t          flag_e_q;
  logic [NdW-1:0] nr_q;
  logic [SW-1:0]  dv_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      flag_e_q <= flag_q[LogLat+3];
      if (!flag_q[LogLat+3].early && (dbad || qbig))
        flag_e_q <= '{early: 1'b1, neg: 1'b0, err: ErrRange};
      nr_q <= (dbad || qbig) ? '0 : nr;
      dv_q <= dbad ? SW'(1) : dpos;
    end
  end

  logic [QW-1:0] quo;
  ntc_div #(.NumW(NdW), .DenW(SW), .QW(QW)) u_div (
    .clk_i, .en_i(en), .num_i(nr_q), .den_i(dv_q), .quo_o(quo)
  );

  flag_t flag_dq [QW+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      flag_dq[0] <= flag_e_q;
      for (int k = 1; k <= QW; k++) flag_dq[k] <= flag_dq[k-1];
    end
  end

  // output register
  logic [TempW-1:0] temp_q;
  logic [1:0]       code_q;
  flag_t            fo;
  assign fo = flag_dq[QW];
  always_ff @(posedge clk_i) begin
    if (en) begin
      code_q <= fo.err;
      if (fo.early) temp_q <= fo.neg ? TempW'(-ZeroK) : TempW'(TempMax);
      else          temp_q <= TempW'(quo - QW'(ZeroK));
    end
  end

  assign m_axis_tdata = {6'b0, code_q, temp_q};

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (code_q != 2'd3)) else $error("bad error code");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q)) else $error("pipe moved on stall");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && code_q == ErrSample) |-> temp_q == TempW'(TempMax))
    else $error("sample error not saturated");

endmodule

FILE: dv/tb_ntc_adc_to_temperature.sv
module tb_ntc_adc_to_temperature;
  import ntc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // log fraction bits of the block instance, and the ln2 scale in Q32
  localparam int unsigned FracBits  = 16;
  localparam logic [63:0] Ln2Q32    = 64'hB172_17F8;
  localparam int unsigned IdlePct   = 6;
  localparam int unsigned HoldLen   = 400;
  localparam int unsigned HoldAt    = 150;
  localparam int unsigned DrainWait = 100;
  localparam int unsigned StuckMax  = 3000;

  typedef struct packed {
    logic signed [15:0] temp;
    err_e               err;
  } temp_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] adc_sample
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [15:0] temp_centi_c, [17:16] error_code

  ntc_adc_to_temperature #(.LOG_FRAC_BITS(FracBits)) i_dut (.*);

  // shadow of the register file, used by the temperature predictor
  logic [21:0] series_r;
  logic [21:0] nominal_r;
  logic [15:0] beta_r;
  logic [7:0]  nom_temp_r;
  logic [4:0]  adc_bits_r;

  logic [15:0] sample_q[$];      // samples waiting to be offered
  temp_res_t   temp_expect_q[$]; // predicted results, oldest first

  int unsigned errors;
  int unsigned samples_in;
  int unsigned results_out;
  int unsigned err_seen[3];
  int unsigned stuck_cnt;
  int unsigned hold_cnt;
  bit          hold_done;
  bit          calm;             // no idling on either side while set

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // log2 in Q FracBits: top bit index plus fraction by repeated squaring
  function automatic logic [63:0] log2_q(logic [63:0] x);
    int unsigned p;
    logic [63:0] y;
    logic [63:0] fr;
    p  = 0;
    fr = '0;
    while ((x >> p) > 64'd1) p++;
    if (p > 30) y = x >> (p - 30);
    else        y = x << (30 - p);
    for (int i = 0; i < FracBits; i++) begin
      y  = (y * y) >> 30;
      fr = fr << 1;
      if (y >= (64'd2 << 30)) begin
        y  = y >> 1;
        fr = fr | 64'd1;
      end
    end
    return (64'(p) << FracBits) | fr;
  endfunction

  // temperature predictor: beta equation in centi-degrees
  function automatic temp_res_t predict_temp(logic [15:0] raw);
    logic [63:0] fs, num, den, mag, t0c, numer, q;
    longint      d, ln_q, inv;
    temp_res_t   r;
    fs = (64'd1 << adc_bits_r) - 64'd1;
    if (raw == 0 || 64'(raw) >= fs) return '{temp: 16'sd32767, err: ErrSample};
    if (series_r == 0) return '{temp: 16'sd32767, err: ErrRange};
    // infinite ratio means absolute zero
    if (nominal_r == 0) return '{temp: -16'sd27315, err: ErrRange};
    num  = 64'(series_r) * 64'(raw);
    den  = 64'(nominal_r) * (fs - 64'(raw));
    d    = longint'(log2_q(num)) - longint'(log2_q(den));
    mag  = (d < 0) ? 64'(-d) : 64'(d);
    mag  = (mag * Ln2Q32 + (64'd1 << 31)) >> 32;
    ln_q = (d < 0) ? -longint'(mag) : longint'(mag);
    t0c  = 64'd100 * 64'(nom_temp_r) + 64'(ZeroK);
    inv  = longint'((64'd100 * 64'(beta_r)) << FracBits) + ln_q * longint'(t0c);
    // non-positive inverse temperature saturates high
    if (inv <= 0) return '{temp: 16'sd32767, err: ErrRange};
    numer = (64'd100 * 64'(beta_r) * t0c) << FracBits;
    q     = (numer + (64'(inv) >> 1)) / 64'(inv);
    if (q > 64'(TempMax + ZeroK)) return '{temp: 16'sd32767, err: ErrRange};
    r.temp = 16'(q - 64'(ZeroK));
    r.err  = ErrNone;
    return r;
  endfunction

  // apb write: setup cycle, then access cycle; shadow follows the write edge
  task automatic reg_write(reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * idx);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegSeries:  series_r   = val[21:0];
      RegNominal: nominal_r  = val[21:0];
      RegBeta:    beta_r     = val[15:0];
      RegNomTemp: nom_temp_r = val[7:0];
      RegAdcBits: adc_bits_r = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [21:0] ser, logic [21:0] nom, logic [15:0] beta,
                            logic [7:0] t0, logic [4:0] bits);
    reg_write(RegSeries, 32'(ser));
    reg_write(RegNominal, 32'(nom));
    reg_write(RegBeta, 32'(beta));
    reg_write(RegNomTemp, 32'(t0));
    reg_write(RegAdcBits, 32'(bits));
  endtask

  // wait for the pipe to drain completely before touching registers
  task automatic drain();
    while (sample_q.size() != 0 || s_axis_tvalid || temp_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // mostly in-range samples with random content, some anywhere in the field, some at full scale
  task automatic push_random(int unsigned n);
    logic [31:0] fs;
    fs = (32'd1 << adc_bits_r) - 32'd1;
    repeat (n) begin
      if ($urandom_range(99) < 85 && adc_bits_r >= 2 && fs > 1)
        sample_q.push_back(16'($urandom_range((fs > 65535) ? 65535 : fs - 1, 1)));
      else if ($urandom_range(1))
        sample_q.push_back(16'($urandom));
      else
        sample_q.push_back(16'(fs + $urandom_range(2) - 1));
    end
  endtask

  // input driver: a beat stays up until taken, random gaps between beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (sample_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready: random stalls plus one long hold-off so the pipe backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
      hold_done     <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && samples_in >= HoldAt) begin
      hold_done     <= 1'b1;
      hold_cnt      <= HoldLen;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // input monitor: predict each accepted sample
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      temp_expect_q.push_back(predict_temp(s_axis_tdata));
      samples_in++;
    end
  end

  // output monitor: field by field against the oldest prediction
  always @(posedge clk_i) begin
    temp_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_out++;
      if (temp_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, actual temp %0d code %0d", $realtime,
                 $signed(m_axis_tdata[15:0]), m_axis_tdata[17:16]);
      end else begin
        exp_r = temp_expect_q.pop_front();
        err_seen[exp_r.err]++;
        if (m_axis_tdata[15:0] !== exp_r.temp) begin
          errors++;
          $display("%0t: temp_centi_c mismatch, expected %0d actual %0d", $realtime,
                   exp_r.temp, $signed(m_axis_tdata[15:0]));
        end
        if (m_axis_tdata[17:16] !== exp_r.err) begin
          errors++;
          $display("%0t: error_code mismatch, expected %0d actual %0d", $realtime,
                   exp_r.err, m_axis_tdata[17:16]);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cnt <= 0;
    else
      stuck_cnt <= stuck_cnt + 1;
    if (stuck_cnt >= StuckMax) begin
      $display("%0t: watchdog, no beat for %0d cycles", $realtime, stuck_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    errors = 0; samples_in = 0; results_out = 0; stuck_cnt = 0;
    err_seen = '{0, 0, 0};
    calm = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    series_r = 22'd10000; nominal_r = 22'd10000; beta_r = 16'd3435;
    nom_temp_r = 8'd25; adc_bits_r = 5'd10;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: zero, one, mid, just below, at and above full scale
    foreach (sample_q[i]) ;
    sample_q = '{16'd0, 16'd1, 16'd2, 16'd512, 16'd1021, 16'd1022, 16'd1023,
                 16'd1024, 16'hFFFF, 16'h8000};
    drain();

    // zero series resistance, zero nominal resistance, zero beta, zero resolution
    set_config(22'd0, 22'd10000, 16'd3435, 8'd25, 5'd10);
    sample_q = '{16'd1, 16'd500};
    drain();
    set_config(22'd10000, 22'd0, 16'd3435, 8'd25, 5'd10);
    sample_q = '{16'd1, 16'd500};
    drain();
    set_config(22'd10000, 22'd10000, 16'd0, 8'd25, 5'd10);
    sample_q = '{16'd100, 16'd511, 16'd900};
    drain();
    set_config(22'd10000, 22'd10000, 16'd3435, 8'd25, 5'd0);
    sample_q = '{16'd0, 16'd1, 16'hFFFF};
    drain();
    // resolution beyond the sample width never reaches full scale
    set_config(22'h3FFFFF, 22'd1, 16'hFFFF, 8'hFF, 5'd31);
    sample_q = '{16'd1, 16'hFFFF, 16'h5555};
    drain();

    // random phases: fixed and extreme settings first, then random settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:  set_config(22'd10000, 22'd10000, 16'd3435, 8'd25, 5'd16);
        1:  set_config(22'd1, 22'h3FFFFF, 16'd1, 8'd0, 5'd12);
        2:  set_config(22'h3FFFFF, 22'h3FFFFF, 16'hFFFF, 8'hFF, 5'd16);
        3:  set_config(22'd4700, 22'd100000, 16'd3950, 8'd25, 5'd1);
        4:  set_config(22'd100000, 22'd4700, 16'd100, 8'd0, 5'd2);
        default:
          set_config(22'($urandom_range(4000000, 1)), 22'($urandom_range(4000000, 1)),
                     16'($urandom_range(65535, 1)), 8'($urandom_range(255)),
                     5'($urandom_range(16, 3)));
      endcase
      calm = (ph == 7);
      push_random(ph == 3 ? 20 : 100);
      drain();
    end
    calm = 1'b0;
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d samples over many register settings, incl. a long output stall",
             samples_in);
    $display("results: %0d ok, %0d sample errors, %0d range errors",
             err_seen[ErrNone], err_seen[ErrSample], err_seen[ErrRange]);
    if (errors == 0 && temp_expect_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0t: %0d predictions left over", $realtime, temp_expect_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ntc_pkg.sv
hdl/ntc_log2.sv
hdl/ntc_div.sv
hdl/ntc_adc_to_temperature.sv
dv/tb_ntc_adc_to_temperature.sv
